### design/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the page table mapper
// Op and status codes, word layouts and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tpm_pkg;

   // field widths
   localparam int FRAME_W    = 20;
   localparam int ATTR_W     = 12;
   localparam int VADDR_W    = 32;
   localparam int ENTRY_W    = 32;
   localparam int IDX_W      = 10;
   localparam int ENTRIES    = 1024;
   localparam int PAGE_SHIFT = 12;

   // pool base after reset
   localparam logic [FRAME_W-1:0] BASE_RESET = 20'd256;

   // op codes
   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_NEWDIR = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_OUTSIDE   = 2'd2;

   // attribute masks
   localparam logic [ATTR_W-1:0] ATTR_PRESENT       = 12'h001;
   localparam logic [ATTR_W-1:0] ATTR_CLEAR_PRESENT = 12'hFFE;

   // memory address select
   localparam logic [1:0] ASEL_PDE = 2'd0;
   localparam logic [1:0] ASEL_PTE = 2'd1;
   localparam logic [1:0] ASEL_CLR = 2'd2;

   // memory write data select
   localparam logic [1:0] WSEL_ZERO = 2'd0;
   localparam logic [1:0] WSEL_PDE  = 2'd1;
   localparam logic [1:0] WSEL_PTE  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [FRAME_W-1:0] dir_frame;
      logic [VADDR_W-1:0] virt_addr;
      logic [FRAME_W-1:0] phys_frame;
      logic [ATTR_W-1:0]  attr_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VADDR_W-1:0] phys_addr;
      logic [FRAME_W-1:0] new_frame;
      logic               table_allocated;
   } rsp_type;

   typedef struct packed {
      logic       latch_req;
      logic       alloc_start;
      logic       cap_pde;
      logic       mem_re;
      logic       mem_we;
      logic [1:0] addr_sel;
      logic [1:0] wdata_sel;
      logic       status_we;
      logic [1:0] status_code;
      logic       set_paddr;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       dir_in_pool;
      logic       pde_present;
      logic       tbl_in_pool;
      logic       pool_full;
      logic       clear_last;
   } stat_type;

endpackage

### design/tpm_ifs.sv
// ----------------------------------------------------------------------------
// tpm_ifs: channel interfaces of the page table mapper
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface tpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  op;
   logic [tpm_pkg::FRAME_W-1:0] dir_frame;
   logic [tpm_pkg::VADDR_W-1:0] virt_addr;
   logic [tpm_pkg::FRAME_W-1:0] phys_frame;
   logic [tpm_pkg::ATTR_W-1:0]  attr_bits;

   modport source (output valid, op, dir_frame, virt_addr, phys_frame, attr_bits,
                   input ready);
   modport sink   (input valid, op, dir_frame, virt_addr, phys_frame, attr_bits,
                   output ready);
endinterface

interface tpm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [tpm_pkg::VADDR_W-1:0] phys_addr;
   logic [tpm_pkg::FRAME_W-1:0] new_frame;
   logic                        table_allocated;

   modport source (output valid, status, phys_addr, new_frame, table_allocated,
                   input ready);
   modport sink   (input valid, status, phys_addr, new_frame, table_allocated,
                   output ready);
endinterface

interface tpm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tpm_pkg::FRAME_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

### design/tpm_ctrl.sv
// ----------------------------------------------------------------------------
// tpm_ctrl: sequencer of the page table mapper
// Walks one request through directory read, optional page allocation with
// clear sweep, directory write and table entry read-modify-write.
// ----------------------------------------------------------------------------
module tpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_busy,
   input  tpm_pkg::stat_type stat,
   output tpm_pkg::cmd_type  cmd
);
   import tpm_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PDE_WAIT = 4'd2;
   localparam logic [3:0] S_CHECK    = 4'd3;
   localparam logic [3:0] S_CLEAR    = 4'd4;
   localparam logic [3:0] S_WR_PDE   = 4'd5;
   localparam logic [3:0] S_RD_PTE   = 4'd6;
   localparam logic [3:0] S_PTE_WAIT = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.op == OP_NEWDIR) begin
               if (stat.pool_full) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = ST_EXHAUSTED;
                  state_in        = S_FINISH;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in        = S_CLEAR;
               end
            end else if (stat.op == OP_MAP || stat.op == OP_UNMAP) begin
               if (!stat.dir_in_pool) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = ST_OUTSIDE;
                  state_in        = S_FINISH;
               end else begin
                  cmd.mem_re   = 1'b1;
                  cmd.addr_sel = ASEL_PDE;
                  state_in     = S_PDE_WAIT;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PDE_WAIT: begin
            cmd.cap_pde = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (stat.op == OP_MAP) begin
               if (!stat.pde_present) begin
                  if (stat.pool_full) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = ST_EXHAUSTED;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.alloc_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
               end else if (!stat.tbl_in_pool) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = ST_OUTSIDE;
                  state_in        = S_FINISH;
               end else begin
                  state_in = S_WR_PDE;
               end
            end else begin
               if (!stat.tbl_in_pool) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = ST_OUTSIDE;
                  state_in        = S_FINISH;
               end else begin
                  cmd.mem_re   = 1'b1;
                  cmd.addr_sel = ASEL_PTE;
                  state_in     = S_PTE_WAIT;
               end
            end
         end
         S_CLEAR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ASEL_CLR;
            cmd.wdata_sel = WSEL_ZERO;
            if (stat.clear_last) begin
               state_in = (stat.op == OP_NEWDIR) ? S_FINISH : S_WR_PDE;
            end
         end
         S_WR_PDE: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ASEL_PDE;
            cmd.wdata_sel = WSEL_PDE;
            state_in      = S_RD_PTE;
         end
         S_RD_PTE: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ASEL_PTE;
            state_in     = S_PTE_WAIT;
         end
         S_PTE_WAIT: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ASEL_PTE;
            cmd.wdata_sel = WSEL_PTE;
            cmd.set_paddr = (stat.op == OP_UNMAP);
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/tpm_datapath.sv
// ----------------------------------------------------------------------------
// tpm_datapath: table storage and arithmetic of the page table mapper
// Page memory with one port and registered read, pool base register, bump
// allocator, clear counter, entry builders and result registers.
// ----------------------------------------------------------------------------
module tpm_datapath #(
   parameter int POOL_PAGES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tpm_pkg::cmd_type            cmd,
   input  tpm_pkg::req_type            req_in,
   input  logic                        csr_we,
   input  logic [tpm_pkg::FRAME_W-1:0] csr_wdata,
   output tpm_pkg::stat_type           stat,
   output tpm_pkg::rsp_type            result
);
   import tpm_pkg::*;

   localparam int SLOT_W    = $clog2(POOL_PAGES);
   localparam int CNT_W     = $clog2(POOL_PAGES + 1);
   localparam int MEM_AW    = SLOT_W + IDX_W;
   localparam int MEM_DEPTH = POOL_PAGES * ENTRIES;

   localparam logic [FRAME_W-1:0] POOL_LIMIT = FRAME_W'(POOL_PAGES);
   localparam logic [CNT_W-1:0]   POOL_COUNT = CNT_W'(POOL_PAGES);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(ENTRIES - 1);

   logic [ENTRY_W-1:0] page_mem_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   req_type            req_ff;
   logic [FRAME_W-1:0] base_ff;
   logic [CNT_W-1:0]   next_free_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [IDX_W-1:0]   clr_cnt_ff;
   logic [ENTRY_W-1:0] pde_ff;
   logic [1:0]         status_ff;
   logic [VADDR_W-1:0] paddr_ff;
   logic [FRAME_W-1:0] nframe_ff;
   logic               talloc_ff;

   logic [FRAME_W-1:0] dir_rel;
   logic [FRAME_W-1:0] tbl_rel;
   logic [FRAME_W-1:0] rd_rel;
   logic [FRAME_W-1:0] alloc_frame;
   logic [IDX_W-1:0]   pdi;
   logic [IDX_W-1:0]   pti;
   logic [MEM_AW-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;

   // pool offsets of frames, wrapping over the 20-bit frame space
   assign dir_rel     = req_ff.dir_frame - base_ff;
   assign tbl_rel     = pde_ff[ENTRY_W-1:PAGE_SHIFT] - base_ff;
   assign rd_rel      = rd_data_ff[ENTRY_W-1:PAGE_SHIFT] - base_ff;
   assign alloc_frame = base_ff + FRAME_W'(next_free_ff);
   assign pdi         = req_ff.virt_addr[VADDR_W-1:VADDR_W-IDX_W];
   assign pti         = req_ff.virt_addr[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];

   // status toward the controller
   always_comb begin
      stat.op          = req_ff.op;
      stat.dir_in_pool = (dir_rel < POOL_LIMIT);
      stat.pde_present = pde_ff[0];
      stat.tbl_in_pool = (tbl_rel < POOL_LIMIT);
      stat.pool_full   = (next_free_ff >= POOL_COUNT);
      stat.clear_last  = (clr_cnt_ff == LAST_IDX);
   end

   // memory address
   always_comb begin
      unique case (cmd.addr_sel)
         ASEL_PDE: mem_addr = {dir_rel[SLOT_W-1:0], pdi};
         ASEL_PTE: mem_addr = {slot_ff, pti};
         ASEL_CLR: mem_addr = {slot_ff, clr_cnt_ff};
         default:  mem_addr = {slot_ff, clr_cnt_ff};
      endcase
   end

   // memory write data
   always_comb begin
      unique case (cmd.wdata_sel)
         WSEL_ZERO: mem_wdata = '0;
         WSEL_PDE: begin
            mem_wdata = {pde_ff[ENTRY_W-1:PAGE_SHIFT],
                         pde_ff[ATTR_W-1:0] | req_ff.attr_bits | ATTR_PRESENT};
         end
         WSEL_PTE: begin
            if (req_ff.op == OP_UNMAP) begin
               mem_wdata = {rd_data_ff[ENTRY_W-1:PAGE_SHIFT],
                            rd_data_ff[ATTR_W-1:0] & ATTR_CLEAR_PRESENT};
            end else begin
               mem_wdata = {req_ff.phys_frame,
                            rd_data_ff[ATTR_W-1:0] | req_ff.attr_bits | ATTR_PRESENT};
            end
         end
         default: mem_wdata = '0;
      endcase
   end

   // page memory, one port, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         page_mem_ff[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_re) begin
         rd_data_ff <= page_mem_ff[mem_addr];
      end
   end

   // pool base register and allocation count
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         next_free_ff <= '0;
      end else begin
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (cmd.alloc_start) begin
            next_free_ff <= next_free_ff + CNT_W'(1);
         end
      end
   end

   // request, walk and result registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff    <= req_in;
         status_ff <= ST_OK;
         paddr_ff  <= '0;
         nframe_ff <= '0;
         talloc_ff <= 1'b0;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.cap_pde) begin
         pde_ff  <= rd_data_ff;
         slot_ff <= rd_rel[SLOT_W-1:0];
      end
      // take the next pool page and, for a map, point the directory entry at it
      if (cmd.alloc_start) begin
         slot_ff    <= next_free_ff[SLOT_W-1:0];
         clr_cnt_ff <= '0;
         nframe_ff  <= alloc_frame;
         if (req_ff.op == OP_MAP) begin
            talloc_ff                      <= 1'b1;
            pde_ff[ENTRY_W-1:PAGE_SHIFT]   <= alloc_frame;
         end
      end
      // advance the clear sweep
      if (cmd.mem_we && cmd.addr_sel == ASEL_CLR) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
      end
      if (cmd.set_paddr) begin
         paddr_ff <= {rd_data_ff[ENTRY_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      end
   end

   always_comb begin
      result.status          = status_ff;
      result.phys_addr       = paddr_ff;
      result.new_frame       = nframe_ff;
      result.table_allocated = talloc_ff;
   end

endmodule

### design/two_level_page_table_mapper_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_mapper_top: two-level page table mapper
// Maintains directory and table pages in a bump-allocated pool held in
// on-chip memory; maps, unmaps and allocates directories one word at a time.
// ----------------------------------------------------------------------------
//   channel   dir  handshake       word contents
//   req_chan  in   valid/ready     op, dir_frame, virt_addr, phys_frame, attr_bits
//   rsp_chan  out  valid/ready     status, phys_addr, new_frame, table_allocated
//   csr_chan  in   valid/ready     pool_base_frame (ready always high)
//
// One request at a time. Unknown op, a directory frame outside the pool or a
// new directory on a full pool finish at dispatch; a table frame outside the
// pool or a map on a full pool, after the directory read; unmap then updates
// its table entry; a map writes its directory entry, then its table entry.
// Each page allocation clears 1024 entries, one per cycle via the single port.
// Synchronous reset clears control state; table memory contents are not reset.
// A result waits in the output register while the next request is accepted;
// the walk stalls only at its end if that register is still full.
// ----------------------------------------------------------------------------
module two_level_page_table_mapper_top #(
   parameter int POOL_PAGES = 64
) (
   input  logic         clock,
   input  logic         reset,
   tpm_req_if.sink      req_chan,
   tpm_rsp_if.source    rsp_chan,
   tpm_csr_if.sink      csr_chan
);
   import tpm_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   req_type  req_word;
   rsp_type  result;
   rsp_type  rsp_data_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     rsp_busy;
   logic     req_ready;

   assign req_word.op         = req_chan.op;
   assign req_word.dir_frame  = req_chan.dir_frame;
   assign req_word.virt_addr  = req_chan.virt_addr;
   assign req_word.phys_frame = req_chan.phys_frame;
   assign req_word.attr_bits  = req_chan.attr_bits;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_busy       = rsp_valid_ff && !rsp_chan.ready;

   tpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_busy  (rsp_busy),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpm_datapath #(
      .POOL_PAGES (POOL_PAGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_in    (req_word),
      .csr_we    (csr_chan.valid),
      .csr_wdata (csr_chan.wdata),
      .stat      (stat),
      .result    (result)
   );

   // output word register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_data_ff.status;
   assign rsp_chan.phys_addr       = rsp_data_ff.phys_addr;
   assign rsp_chan.new_frame       = rsp_data_ff.new_frame;
   assign rsp_chan.table_allocated = rsp_data_ff.table_allocated;

   // a finished word never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_busy)
      else $error("result loaded over a pending word");

   // a loaded result is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_chan.valid)
      else $error("loaded result not offered");

   // one request in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while one is in flight");

   // the pool, once used up, stays used up
   assert property (@(posedge clock) disable iff (reset)
      stat.pool_full |=> stat.pool_full)
      else $error("allocation count went backward");

endmodule
